### design/chg_pkg.sv
// Shared constants and types for the cell-hashed Gaussian noise generator.
package chg_pkg;

  // splitmix64 constants
  localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;
  // state increments for the three draws: 1, 2 and 3 times the golden step
  localparam logic [63:0] DRAW_INC [3] = '{64'h9E3779B97F4A7C15,
                                           64'h3C6EF372FE94F82A,
                                           64'hDAA66D2C7DDF743F};

  localparam int U_W     = 53;   // uniform fraction width
  localparam int PHASE_W = 32;   // phase taken from the top of v
  localparam int RAD_W   = 24;   // radius, Q.20
  localparam int MAG_W   = 31;   // trig magnitude, Q.30

  localparam logic [30:0] TWO_LN2_Q30 = 31'h58B90BFC;
  localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;

  localparam int RAD_LAT  = 62;  // u in to radius out
  localparam int TRIG_LAT = 22;  // phase in to magnitude out

  // Taylor series divisors n*(n-1)
  localparam logic [7:0] COS_DIV [6] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [7:0] SIN_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

  // register indexes
  localparam int          CFG_IDX_W = 1;
  localparam logic [0:0]  REG_SEED  = 1'd0;
  localparam logic [0:0]  REG_NORM  = 1'd1;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } trig_t;

endpackage

### design/chg_radius.sv
// Radius pipeline: sqrt(-2 ln u) through normalise, log2 by squaring and bitwise sqrt.
module chg_radius (
  input  logic                       clk,
  input  logic                       en,
  input  logic [chg_pkg::U_W-1:0]    u,
  output logic [chg_pkg::RAD_W-1:0]  radius
);
  import chg_pkg::*;

  localparam int NSTEP = 6;
  localparam int LOGB  = 30;
  localparam int SQB   = 24;
  localparam int XW    = 2 * SQB;

  // normalise: leading zero count by halving steps
  logic [U_W-1:0] nw [0:NSTEP];
  logic [5:0]     nz [0:NSTEP];
  assign nw[0] = u;
  assign nz[0] = '0;

  for (genvar k = 0; k < NSTEP; k++) begin : g_norm
    localparam int K = 32 >> k;
    always_ff @(posedge clk) begin
      if (en) begin
        if (nw[k][U_W-1 -: K] == '0) begin
          nw[k+1] <= nw[k] << K;
          nz[k+1] <= nz[k] + 6'(K);
        end else begin
          nw[k+1] <= nw[k];
          nz[k+1] <= nz[k];
        end
      end
    end
  end

  // fraction bits of log2 by repeated squaring of the Q1.30 mantissa
  logic [30:0] sm [0:LOGB];
  logic [29:0] sf [0:LOGB];
  logic [5:0]  sz [0:LOGB];
  assign sm[0] = nw[NSTEP][U_W-1 -: 31];
  assign sf[0] = '0;
  assign sz[0] = nz[NSTEP];

  for (genvar n = 0; n < LOGB; n++) begin : g_sq
    localparam logic [29:0] BITMASK = 30'(1) << (LOGB - 1 - n);
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = sm[n] * sm[n];
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        sz[n+1] <= sz[n];
        if (t[31]) begin
          sm[n+1] <= t[31:1];
          sf[n+1] <= sf[n] | BITMASK;
        end else begin
          sm[n+1] <= t[30:0];
          sf[n+1] <= sf[n];
        end
      end
    end
  end

  // -log2(u) in Q6.30 = (lz + 1) - frac, kept as Q6.24
  logic [35:0] nl_full;
  logic [29:0] nl_q24;
  assign nl_full = {6'(sz[LOGB] + 6'd1), 30'd0} - {6'd0, sf[LOGB]};

  always_ff @(posedge clk) begin
    if (en) nl_q24 <= nl_full[35:6];
  end

  // -2 ln u in Q.40
  logic [60:0]   prod;
  logic [XW-2:0] x_q40;
  assign prod = nl_q24 * TWO_LN2_Q30;

  always_ff @(posedge clk) begin
    if (en) x_q40 <= prod[60:14];
  end

  // floor sqrt, two radicand bits a stage
  logic [XW-1:0]    qx    [0:SQB];
  logic [SQB+1:0]   qrem  [0:SQB];
  logic [SQB-1:0]   qroot [0:SQB];
  assign qx[0]    = {1'b0, x_q40};
  assign qrem[0]  = '0;
  assign qroot[0] = '0;

  for (genvar k = 0; k < SQB; k++) begin : g_sqrt
    logic [SQB+3:0] remn;
    logic [SQB+3:0] trial;
    assign remn  = {qrem[k], qx[k][XW-1 -: 2]};
    assign trial = {2'b00, qroot[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        qx[k+1] <= qx[k] << 2;
        if (remn >= trial) begin
          qrem[k+1]  <= (SQB+2)'(remn - trial);
          qroot[k+1] <= {qroot[k][SQB-2:0], 1'b1};
        end else begin
          qrem[k+1]  <= (SQB+2)'(remn);
          qroot[k+1] <= {qroot[k][SQB-2:0], 1'b0};
        end
      end
    end
  end

  assign radius = qroot[SQB];

endmodule

### design/chg_trig.sv
// Trig pipeline: |cos(2 pi v)| and its sign via octant fold and Taylor series.
module chg_trig (
  input  logic                         clk,
  input  logic                         en,
  input  logic [chg_pkg::PHASE_W-1:0]  phase,
  output chg_pkg::trig_t               trig
);
  import chg_pkg::*;

  localparam int NT = 6;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [29:0] x2;
    logic [31:0] csum;
    logic [31:0] ssum;
    logic [1:0]  quad;
    logic        swap;
  } carry_t;

  // fold into the first eighth turn
  logic [29:0] r_in;
  logic        sw_in;
  logic [29:0] r1;
  logic [1:0]  q1;
  logic        sw1;
  assign r_in  = phase[29:0];
  assign sw_in = r_in > 30'h2000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      q1  <= phase[31:30];
      sw1 <= sw_in;
      r1  <= sw_in ? 30'(31'h4000_0000 - {1'b0, r_in}) : r_in;
    end
  end

  // angle in radians, Q.30
  logic [60:0] xp;
  logic [29:0] x2r;
  logic [1:0]  q2;
  logic        sw2;
  assign xp = r1 * HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      x2r <= xp[59:30];
      q2  <= q1;
      sw2 <= sw1;
    end
  end

  // x squared; series seeds
  logic [59:0] xsq;
  carry_t      cy [0:NT];
  logic [30:0] tc [0:NT];
  logic [30:0] ts [0:NT];
  assign xsq = x2r * x2r;

  always_ff @(posedge clk) begin
    if (en) begin
      cy[0].x2   <= xsq[59:30];
      cy[0].csum <= 32'h4000_0000;
      cy[0].ssum <= {2'b00, x2r};
      cy[0].quad <= q2;
      cy[0].swap <= sw2;
      tc[0]      <= 31'h4000_0000;
      ts[0]      <= {1'b0, x2r};
    end
  end

  // one term pair per three stages: product, reciprocal estimate, correction
  for (genvar k = 0; k < NT; k++) begin : g_term
    localparam logic [31:0] MC = 32'((64'd1 << 32) / COS_DIV[k]);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / SIN_DIV[k]);
    localparam logic [29:0] DC = 30'(COS_DIV[k]);
    localparam logic [29:0] DS = 30'(SIN_DIV[k]);

    carry_t      cya, cyb;
    logic [60:0] mc_a, ms_a;
    logic [29:0] pca, psa;
    logic [61:0] mc_b, ms_b;
    logic [29:0] pcb, psb, ecb, esb;
    logic [29:0] rc, rs, qc, qs;

    assign mc_a = tc[k] * cy[k].x2;
    assign ms_a = ts[k] * cy[k].x2;

    always_ff @(posedge clk) begin
      if (en) begin
        cya <= cy[k];
        pca <= mc_a[59:30];
        psa <= ms_a[59:30];
      end
    end

    assign mc_b = pca * MC;
    assign ms_b = psa * MS;

    always_ff @(posedge clk) begin
      if (en) begin
        cyb <= cya;
        pcb <= pca;
        psb <= psa;
        ecb <= mc_b[61:32];
        esb <= ms_b[61:32];
      end
    end

    // estimate is at most one short
    assign rc = pcb - 30'(ecb * DC);
    assign rs = psb - 30'(esb * DS);
    assign qc = ecb + 30'(rc >= DC);
    assign qs = esb + 30'(rs >= DS);

    always_ff @(posedge clk) begin
      if (en) begin
        tc[k+1]      <= {1'b0, qc};
        ts[k+1]      <= {1'b0, qs};
        cy[k+1].x2   <= cyb.x2;
        cy[k+1].quad <= cyb.quad;
        cy[k+1].swap <= cyb.swap;
        if ((k % 2) == 0) begin
          cy[k+1].csum <= cyb.csum - {2'b00, qc};
          cy[k+1].ssum <= cyb.ssum - {2'b00, qs};
        end else begin
          cy[k+1].csum <= cyb.csum + {2'b00, qc};
          cy[k+1].ssum <= cyb.ssum + {2'b00, qs};
        end
      end
    end
  end

  // undo the fold and pick by quadrant
  logic [31:0] cs_f, sn_f;
  assign cs_f = cy[NT].swap ? cy[NT].ssum : cy[NT].csum;
  assign sn_f = cy[NT].swap ? cy[NT].csum : cy[NT].ssum;

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (cy[NT].quad)
        QUAD_0: begin trig.mag <= cs_f[MAG_W-1:0]; trig.neg <= 1'b0; end
        QUAD_1: begin trig.mag <= sn_f[MAG_W-1:0]; trig.neg <= 1'b1; end
        QUAD_2: begin trig.mag <= cs_f[MAG_W-1:0]; trig.neg <= 1'b1; end
        QUAD_3: begin trig.mag <= sn_f[MAG_W-1:0]; trig.neg <= 1'b0; end
        default: begin trig.mag <= cs_f[MAG_W-1:0]; trig.neg <= 1'b0; end
      endcase
    end
  end

endmodule

### design/cell_hashed_gaussian_noise_top.sv
// Top level: cell hash, draw mixing, Box-Muller pipeline and density factor.
//
//   channel | signals                                  | beat
//   --------+------------------------------------------+-------------------------------
//   in      | in_valid, in_ready                       | mesh_block, cell_i/j/k
//   out     | out_valid, out_ready                     | gauss_sample, scale_factor
//   cfg     | cfg_we, cfg_index, cfg_data              | seed (0), noise_norm (1)
//
// One beat a cycle in and out while the output is not stalled; 76 register stages, most of
// them the 30 log2 squaring stages and 24 square root stages
// of the radius path.
// Reset (rst, synchronous) clears the stage valid bits and both registers.
// A stall at the output freezes every stage together; no beat is lost or repeated.
module cell_hashed_gaussian_noise_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [30:0]                     mesh_block,
  input  logic [3:0]                      cell_i,
  input  logic [3:0]                      cell_j,
  input  logic [3:0]                      cell_k,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [20:0]              gauss_sample,
  output logic signed [31:0]              scale_factor,
  input  logic                            cfg_we,
  input  logic [chg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);
  import chg_pkg::*;

  localparam int HASH_LAT = 10;
  localparam int FIN_LAT  = 4;
  localparam int TOTAL    = HASH_LAT + RAD_LAT + FIN_LAT;
  localparam int DLY      = RAD_LAT - TRIG_LAT;

  // configuration
  logic [63:0] seed;
  logic [31:0] noise_norm;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= '0;
      noise_norm <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED: seed       <= cfg_data;
        REG_NORM: noise_norm <= cfg_data[31:0];
        default:  ;
      endcase
    end
  end

  // pipeline advance and valid bits
  logic             en;
  logic [TOTAL-1:0] vld;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], in_valid};
    end
  end
  assign out_valid = vld[TOTAL-1];

  // cell hash: four golden steps, each followed by a coordinate xor
  logic [63:0] sa, sb, sc, sd;
  logic [3:0]  ci1, cj1, ck1, cj2, ck2, ck3;

  always_ff @(posedge clk) begin
    if (en) begin
      sa  <= (seed + GOLDEN) ^ {33'd0, mesh_block};
      ci1 <= cell_i;
      cj1 <= cell_j;
      ck1 <= cell_k;
      sb  <= (sa + GOLDEN) ^ {60'd0, ci1};
      cj2 <= cj1;
      ck2 <= ck1;
      sc  <= (sb + GOLDEN) ^ {60'd0, cj2};
      ck3 <= ck2;
      sd  <= (sc + GOLDEN) ^ {60'd0, ck3};
    end
  end

  // three splitmix64 draws; 64-bit products split into 32-bit partials
  logic [63:0] draw [3];

  for (genvar n = 0; n < 3; n++) begin : g_draw
    logic [63:0] z, y, w, p1, p2;
    logic [63:0] ll1, lh1, hl1, ll2, lh2, hl2;
    logic [63:0] pl1, pl2;
    logic [31:0] pm1, ph1, pm2, ph2;

    assign z   = sd + DRAW_INC[n];
    assign ll1 = y[31:0]  * MIX_MUL1[31:0];
    assign lh1 = y[31:0]  * MIX_MUL1[63:32];
    assign hl1 = y[63:32] * MIX_MUL1[31:0];
    assign p1  = pl1 + {pm1 + ph1, 32'd0};
    assign ll2 = w[31:0]  * MIX_MUL2[31:0];
    assign lh2 = w[31:0]  * MIX_MUL2[63:32];
    assign hl2 = w[63:32] * MIX_MUL2[31:0];
    assign p2  = pl2 + {pm2 + ph2, 32'd0};

    always_ff @(posedge clk) begin
      if (en) begin
        y       <= z ^ (z >> 30);
        pl1     <= ll1;
        pm1     <= lh1[31:0];
        ph1     <= hl1[31:0];
        w       <= p1 ^ (p1 >> 27);
        pl2     <= ll2;
        pm2     <= lh2[31:0];
        ph2     <= hl2[31:0];
        draw[n] <= p2 ^ (p2 >> 31);
      end
    end
  end

  // pick u and v; a zero first draw shifts to the next pair, and u is one if that draw is zero too
  logic [U_W-1:0]     u_r;
  logic [PHASE_W-1:0] phase_r;
  logic               d1_zero, d2_zero;
  assign d1_zero = (draw[0][63:11] == '0);
  assign d2_zero = (draw[1][63:11] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (d1_zero) begin
        u_r     <= d2_zero ? U_W'(1) : draw[1][63:11];
        phase_r <= draw[2][63:32];
      end else begin
        u_r     <= draw[0][63:11];
        phase_r <= draw[1][63:32];
      end
    end
  end

  logic [RAD_W-1:0] radius;
  trig_t            trig;

  chg_radius u_radius (
    .clk    (clk),
    .en     (en),
    .u      (u_r),
    .radius (radius)
  );

  chg_trig u_trig (
    .clk   (clk),
    .en    (en),
    .phase (phase_r),
    .trig  (trig)
  );

  // align the trig result with the longer radius path
  trig_t tdl [0:DLY];
  assign tdl[0] = trig;

  for (genvar k = 0; k < DLY; k++) begin : g_tdl
    always_ff @(posedge clk) begin
      if (en) tdl[k+1] <= tdl[k];
    end
  end

  // sample and factor
  logic [54:0] rm;
  logic        neg1;
  logic [55:0] gs;
  logic [20:0] g2, g3;
  logic        neg2, neg3, diff3;
  logic [31:0] nm;
  logic [52:0] prod3;
  logic [53:0] tr;
  logic [37:0] t4;
  logic signed [39:0] f4;

  assign gs = {1'b0, rm} + (56'd1 << 33);
  assign nm = noise_norm[31] ? 32'(-noise_norm) : noise_norm;
  assign tr = {1'b0, prod3} + (54'd1 << 15);
  assign t4 = tr[53:16];
  assign f4 = diff3 ? (40'sd16777216 - signed'({2'b00, t4}))
                    : (40'sd16777216 + signed'({2'b00, t4}));

  always_ff @(posedge clk) begin
    if (en) begin
      rm    <= radius * tdl[DLY].mag;
      neg1  <= tdl[DLY].neg;
      g2    <= gs[54:34];
      neg2  <= neg1 & (gs[54:34] != '0);
      prod3 <= nm * g2;
      g3    <= g2;
      neg3  <= neg2;
      diff3 <= noise_norm[31] ^ neg2;
      gauss_sample <= neg3 ? signed'(21'(-g3)) : signed'(g3);
      if (f4 > 40'sd2147483647)
        scale_factor <= 32'sh7FFFFFFF;
      else if (f4 < -40'sd2147483648)
        scale_factor <= 32'sh80000000;
      else
        scale_factor <= f4[31:0];
    end
  end

  a_u_nonzero: assert property (@(posedge clk) disable iff (rst)
      vld[HASH_LAT-1] |-> (u_r != '0))
    else $error("log argument reached the radius path as zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      !en |=> $stable(vld))
    else $error("stage valid bits moved during a stall");

  a_zero_unit: assert property (@(posedge clk) disable iff (rst)
      (out_valid && gauss_sample == 21'sd0) |-> (scale_factor == 32'sh01000000))
    else $error("zero sample gave a factor other than one");

endmodule

### sim/cell_hashed_gaussian_noise_top_tb.sv
// Testbench for the cell-hashed Gaussian noise generator: random beats against a built-in predictor.
`timescale 1ns / 100ps

module cell_hashed_gaussian_noise_top_tb;
  import chg_pkg::*;

  localparam int LATENCY = 76;

  typedef struct {
    logic [30:0] blk;
    logic [3:0]  ci, cj, ck;
  } cell_t;

  typedef struct {
    logic [20:0] gauss;
    logic [31:0] factor;
  } noise_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic [30:0] mesh_block = '0;
  logic [3:0] cell_i = '0, cell_j = '0, cell_k = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [20:0] gauss_sample;
  logic signed [31:0] scale_factor;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEED;
  logic [63:0] cfg_data = '0;

  cell_t  cells_pending[$];
  noise_t noise_due[$];
  logic [63:0] seed_reg = '0;
  logic [31:0] norm_reg = '0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic idle_gaps = 1'b1;
  int   in_gap = 0, out_stall = 0;
  int   mismatches = 0;

  cell_hashed_gaussian_noise_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] splitmix(ref logic [63:0] s);
    logic [63:0] z;
    s = s + GOLDEN;
    z = s;
    z = (z ^ (z >> 30)) * MIX_MUL1;
    z = (z ^ (z >> 27)) * MIX_MUL2;
    return z ^ (z >> 31);
  endfunction

  function automatic noise_t gaussian_for_cell(cell_t c);
    logic [63:0] s, d1, d2, d3, u, v, m, f, nl, prod, x, rem, rad, bitv;
    logic [63:0] phase, q, r, x2, term, cs, sn, mag, g, nm, t, tmp;
    logic swap, neg_g, neg_n;
    longint fac;
    int p;
    noise_t res;
    s = seed_reg;
    void'(splitmix(s)); s ^= {33'd0, c.blk};
    void'(splitmix(s)); s ^= {60'd0, c.ci};
    void'(splitmix(s)); s ^= {60'd0, c.cj};
    void'(splitmix(s)); s ^= {60'd0, c.ck};
    d1 = splitmix(s); d2 = splitmix(s); d3 = splitmix(s);
    u = d1 >> 11;
    if (u == 0) begin
      u = d2 >> 11;
      v = d3 >> 11;
    end else begin
      v = d2 >> 11;
    end
    if (u == 0) u = 1;
    // -log2(u) in Q6.30 by repeated squaring
    p = 0;
    while (p < 63 && (u >> (p + 1)) != 0) p++;
    m = (p >= 30) ? (u >> (p - 30)) : (u << (30 - p));
    f = 0;
    for (int n = 29; n >= 0; n--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        f |= 64'd1 << n;
      end
    end
    nl = (64'(53 - p) << 30) - f;
    prod = (nl >> 6) * 64'(TWO_LN2_Q30);
    // floor square root
    rem = prod >> 14;
    rad = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= rad + bitv) begin
        rem = rem - (rad + bitv);
        rad = (rad >> 1) + bitv;
      end else begin
        rad = rad >> 1;
      end
      bitv = bitv >> 2;
    end
    // cos(2 pi v), folded to the first eighth turn
    phase = v >> 21;
    q = (phase >> 30) & 3;
    r = phase & 64'h3FFF_FFFF;
    swap = r > 64'h2000_0000;
    if (swap) r = 64'h4000_0000 - r;
    x = (r * 64'(HALF_PI_Q30)) >> 30;
    x2 = (x * x) >> 30;
    term = 64'h4000_0000;
    cs = term;
    for (int n = 2; n <= 12; n += 2) begin
      term = ((term * x2) >> 30) / 64'(n * (n - 1));
      if (((n / 2) & 1) != 0) cs = cs - term;
      else cs = cs + term;
    end
    term = x;
    sn = x;
    for (int n = 3; n <= 13; n += 2) begin
      term = ((term * x2) >> 30) / 64'(n * (n - 1));
      if ((((n - 1) / 2) & 1) != 0) sn = sn - term;
      else sn = sn + term;
    end
    if (swap) begin
      tmp = sn; sn = cs; cs = tmp;
    end
    mag = (q == 0 || q == 2) ? cs : sn;
    neg_g = (q == 1 || q == 2);
    g = (rad * mag + (64'd1 << 33)) >> 34;
    if (g == 0) neg_g = 1'b0;
    neg_n = norm_reg[31];
    nm = neg_n ? ((64'd1 << 32) - {32'd0, norm_reg}) : {32'd0, norm_reg};
    t = (nm * g + (64'd1 << 15)) >> 16;
    if (neg_n != neg_g) fac = (longint'(1) << 24) - longint'(t);
    else fac = (longint'(1) << 24) + longint'(t);
    if (fac > 64'sh7FFF_FFFF) fac = 64'sh7FFF_FFFF;
    if (fac < -64'sh8000_0000) fac = -64'sh8000_0000;
    tmp = neg_g ? (64'd0 - g) : g;
    res.gauss = tmp[20:0];
    res.factor = fac[31:0];
    return res;
  endfunction

  // input side: one beat per pending cell, random gap between beats while idle_gaps is set
  always @(negedge clk) begin
    cell_t c;
    if (!rst && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (cells_pending.size() > 0) begin
        c = cells_pending.pop_front();
        mesh_block <= c.blk;
        cell_i <= c.ci;
        cell_j <= c.cj;
        cell_k <= c.ck;
        in_valid <= 1'b1;
        in_gap <= idle_gaps ? $urandom_range(0, 5) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random stall before each beat while idle_gaps is set
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) out_stall = idle_gaps ? $urandom_range(0, 5) : 0;
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cell_t c;
    noise_t want;
    in_fire <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    if (in_valid && in_ready) begin
      c.blk = mesh_block; c.ci = cell_i; c.cj = cell_j; c.ck = cell_k;
      noise_due.push_back(gaussian_for_cell(c));
    end
    if (out_valid && out_ready) begin
      if (noise_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: gauss %h factor %h", gauss_sample, scale_factor);
      end else begin
        want = noise_due.pop_front();
        if (gauss_sample !== want.gauss || scale_factor !== want.factor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: gauss exp %h got %h, factor exp %h got %h",
                     want.gauss, gauss_sample, want.factor, scale_factor);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_SEED) seed_reg = val;
    else norm_reg = val[31:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cell(logic [30:0] b, logic [3:0] i, logic [3:0] j, logic [3:0] k);
    cell_t c;
    c.blk = b; c.ci = i; c.cj = j; c.ck = k;
    cells_pending.push_back(c);
  endtask

  task automatic drain;
    wait (cells_pending.size() == 0 && !in_valid && noise_due.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    logic [63:0] seeds[6];
    logic [31:0] norms[6];
    logic [30:0] b;
    seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom},
              64'd0, {$urandom, $urandom}};
    norms = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0040_0000, 32'hFFFF_FFFF, $urandom};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      idle_gaps = (ph != 3);
      if (ph > 0) begin
        // norm first at the zero setting too, so reset values are overwritten
        write_reg(REG_NORM, {32'd0, norms[ph]});
        write_reg(REG_SEED, seeds[ph]);
      end
      if (ph < 2) begin
        // field extremes and walking bits
        queue_cell(31'd0, 4'd0, 4'd0, 4'd0);
        queue_cell(31'h7FFF_FFFF, 4'hF, 4'hF, 4'hF);
        queue_cell(31'h7FFF_FFFF, 4'd0, 4'hF, 4'd0);
        queue_cell(31'd0, 4'hF, 4'd0, 4'hF);
        for (int n = 0; n < 12; n++)
          queue_cell(31'd1 << (n * 31 / 12), 4'd1 << (n % 4), 4'd1 << ((n + 1) % 4),
                     4'd1 << ((n + 2) % 4));
      end
      for (int n = 0; n < 275; n++) begin
        b = 31'($urandom);
        if ($urandom_range(0, 7) == 0)
          b = $urandom_range(0, 3) ? 31'($urandom_range(0, 64)) : b;
        queue_cell(b, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)));
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
